// ----- sv/segment_intersection_test_top_macros.svh -----
// Assertion macros for the segment intersection test.
// Used by segment_intersection_test_top; no other dependencies.
`ifndef SEGMENT_INTERSECTION_TEST_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SIT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("segment intersection assertion failed");
// next-cycle implication
`define SIT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("segment intersection assertion failed");
`else
`define SIT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SIT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/segisect_pkg.sv -----
// Shared types and constants for the segment intersection test.
// No dependencies.
package segisect_pkg;

    // configuration register indexes
    localparam logic REG_ORIENT_EPS = 1'b0;
    localparam logic REG_BBOX_EPS   = 1'b1;

    localparam int ORIENT_EPS_W = 16;
    localparam int BBOX_EPS_W   = 8;
    localparam int CFG_DATA_W   = 16;

    localparam logic [ORIENT_EPS_W-1:0] ORIENT_EPS_RST = 16'd1;
    localparam logic [BBOX_EPS_W-1:0]   BBOX_EPS_RST   = 8'd0;

    // result codes
    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_TOUCH = 2'd1;
    localparam logic [1:0] HIT_CROSS = 2'd2;

    localparam int OUT_DATA_W = 8;
    localparam int NUM_STAGES = 9;

    typedef struct packed {
        logic nz;   // |v| < eps
        logic pos;  // v > eps
        logic neg;  // v < -eps
    } orient_flags_t;

endpackage

// ----- sv/segment_intersection_test_top.sv -----
// Segment intersection test, top level; uses segisect_pkg and the assertion macro header.
// Takes one pair of segments AB, CD per beat (signed Q15.8 corners, COORD_BITS wide each)
// and returns one beat saying whether they touch or cross. A beat can enter every cycle;
// each result comes out of the nine-register pipeline
// (corner differences, products, cross products, denominator and sign tests, touch test
// and sign normalisation, crossing-window multiply in two halves, window sum, window
// compare, result register). While a result waits on m_tvalid with m_tready low the whole
// pipeline holds and s_tready drops with it; s_tready is also low during reset.
// orient_eps and bbox_eps are written through the cfg port and should only change while
// no beat is in flight.

`include "segment_intersection_test_top_macros.svh"

module segment_intersection_test_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input beat
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bits up
    input  logic [8*COORD_BITS-1:0]               s_tdata,
    // result beat
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // intersects [0], hit_kind [2:1], zero fill above
    output logic [segisect_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_index,
    input  logic [segisect_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int CB = COORD_BITS;
    localparam int DFW = CB + 1;          // corner difference
    localparam int PW  = 2 * CB + 2;      // single product
    localparam int DW  = 2 * CB + 3;      // cross product
    localparam int AW  = DW - 1;          // magnitude of denominator
    localparam int HL  = AW / 2;          // low half of split multiply
    localparam int HH  = AW - HL;
    localparam int LW  = AW + segisect_pkg::ORIENT_EPS_W;
    localparam int CW  = LW + 1;          // signed window compare
    localparam int NS  = segisect_pkg::NUM_STAGES;

    // ------------------------------------------------------------------
    // configuration
    logic [segisect_pkg::ORIENT_EPS_W-1:0] orient_eps_reg;
    logic [segisect_pkg::BBOX_EPS_W-1:0]   bbox_eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_eps_reg <= segisect_pkg::ORIENT_EPS_RST;
            bbox_eps_reg   <= segisect_pkg::BBOX_EPS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                segisect_pkg::REG_ORIENT_EPS: orient_eps_reg <= cfg_wdata;
                segisect_pkg::REG_BBOX_EPS:
                    bbox_eps_reg <= cfg_wdata[segisect_pkg::BBOX_EPS_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [DFW-1:0] margin;
    logic signed [DW-1:0]  eps_w;
    assign margin = $signed({{(DFW - segisect_pkg::BBOX_EPS_W){1'b0}}, bbox_eps_reg});
    assign eps_w  = $signed({{(DW - segisect_pkg::ORIENT_EPS_W){1'b0}}, orient_eps_reg});

    function automatic segisect_pkg::orient_flags_t orient_flags(
        input logic signed [DW-1:0] v,
        input logic signed [DW-1:0] e
    );
        segisect_pkg::orient_flags_t f;
        f.nz  = (v < e) && (v > -e);
        f.pos = v > e;
        f.neg = v < -e;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // pipeline control: one enable for every stage
    logic          en;
    logic [NS-1:0] v_reg;

    assign en       = !v_reg[NS-1] || m_tready;
    assign s_tready = aresetn && en;
    assign m_tvalid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: corner differences and widened bounding boxes
    logic signed [CB-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
    assign a_x = s_tdata[0*CB +: CB];
    assign a_y = s_tdata[1*CB +: CB];
    assign b_x = s_tdata[2*CB +: CB];
    assign b_y = s_tdata[3*CB +: CB];
    assign c_x = s_tdata[4*CB +: CB];
    assign c_y = s_tdata[5*CB +: CB];
    assign d_x = s_tdata[6*CB +: CB];
    assign d_y = s_tdata[7*CB +: CB];

    logic signed [DFW-1:0] bax_reg, bay_reg, cax_reg, cay_reg;
    logic signed [DFW-1:0] dax_reg, day_reg, dcx_reg, dcy_reg;
    // box corners: [0] x low, [1] x high, [2] y low, [3] y high
    logic signed [DFW-1:0] ab_box_reg [4];
    logic signed [DFW-1:0] cd_box_reg [4];
    logic signed [CB-1:0]  ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [CB-1:0]  cx1_reg, cy1_reg, dx1_reg, dy1_reg;

    logic signed [CB-1:0] ab_xmin, ab_xmax, ab_ymin, ab_ymax;
    logic signed [CB-1:0] cd_xmin, cd_xmax, cd_ymin, cd_ymax;

    always_comb begin
        ab_xmin = (a_x < b_x) ? a_x : b_x;
        ab_xmax = (a_x < b_x) ? b_x : a_x;
        ab_ymin = (a_y < b_y) ? a_y : b_y;
        ab_ymax = (a_y < b_y) ? b_y : a_y;
        cd_xmin = (c_x < d_x) ? c_x : d_x;
        cd_xmax = (c_x < d_x) ? d_x : c_x;
        cd_ymin = (c_y < d_y) ? c_y : d_y;
        cd_ymax = (c_y < d_y) ? d_y : c_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bax_reg <= DFW'(b_x) - DFW'(a_x);
            bay_reg <= DFW'(b_y) - DFW'(a_y);
            cax_reg <= DFW'(c_x) - DFW'(a_x);
            cay_reg <= DFW'(c_y) - DFW'(a_y);
            dax_reg <= DFW'(d_x) - DFW'(a_x);
            day_reg <= DFW'(d_y) - DFW'(a_y);
            dcx_reg <= DFW'(d_x) - DFW'(c_x);
            dcy_reg <= DFW'(d_y) - DFW'(c_y);
            ab_box_reg[0] <= DFW'(ab_xmin) - margin;
            ab_box_reg[1] <= DFW'(ab_xmax) + margin;
            ab_box_reg[2] <= DFW'(ab_ymin) - margin;
            ab_box_reg[3] <= DFW'(ab_ymax) + margin;
            cd_box_reg[0] <= DFW'(cd_xmin) - margin;
            cd_box_reg[1] <= DFW'(cd_xmax) + margin;
            cd_box_reg[2] <= DFW'(cd_ymin) - margin;
            cd_box_reg[3] <= DFW'(cd_ymax) + margin;
            ax1_reg <= a_x;
            ay1_reg <= a_y;
            bx1_reg <= b_x;
            by1_reg <= b_y;
            cx1_reg <= c_x;
            cy1_reg <= c_y;
            dx1_reg <= d_x;
            dy1_reg <= d_y;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: six products; endpoint-in-box flags in order C, D, A, B
    logic signed [PW-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg, p3a_reg, p3b_reg;
    logic [3:0]           box2_reg;

    function automatic logic in_box(
        input logic signed [CB-1:0]  rx,
        input logic signed [CB-1:0]  ry,
        input logic signed [DFW-1:0] xlo,
        input logic signed [DFW-1:0] xhi,
        input logic signed [DFW-1:0] ylo,
        input logic signed [DFW-1:0] yhi
    );
        return (DFW'(rx) >= xlo) && (DFW'(rx) <= xhi) &&
               (DFW'(ry) >= ylo) && (DFW'(ry) <= yhi);
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            p1a_reg <= bax_reg * cay_reg;
            p1b_reg <= bay_reg * cax_reg;
            p2a_reg <= bax_reg * day_reg;
            p2b_reg <= bay_reg * dax_reg;
            p3a_reg <= cax_reg * dcy_reg;
            p3b_reg <= cay_reg * dcx_reg;
            box2_reg[0] <= in_box(cx1_reg, cy1_reg, ab_box_reg[0], ab_box_reg[1],
                                  ab_box_reg[2], ab_box_reg[3]);
            box2_reg[1] <= in_box(dx1_reg, dy1_reg, ab_box_reg[0], ab_box_reg[1],
                                  ab_box_reg[2], ab_box_reg[3]);
            box2_reg[2] <= in_box(ax1_reg, ay1_reg, cd_box_reg[0], cd_box_reg[1],
                                  cd_box_reg[2], cd_box_reg[3]);
            box2_reg[3] <= in_box(bx1_reg, by1_reg, cd_box_reg[0], cd_box_reg[1],
                                  cd_box_reg[2], cd_box_reg[3]);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: orientations o1 (ABC), o2 (ABD), o3 (CDA); o3 is also the numerator
    logic signed [DW-1:0] o1_reg, o2_reg, o3_reg;
    logic [3:0]           box3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            o1_reg   <= DW'(p1a_reg) - DW'(p1b_reg);
            o2_reg   <= DW'(p2a_reg) - DW'(p2b_reg);
            o3_reg   <= DW'(p3a_reg) - DW'(p3b_reg);
            box3_reg <= box2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: den = o2 - o1, o4 = o3 - den; sign flags of o1..o3
    logic signed [DW-1:0]        den4_reg, o4_reg, num4_reg;
    segisect_pkg::orient_flags_t f1_reg, f2_reg, f3_reg;
    logic [3:0]                  box4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den4_reg <= o2_reg - o1_reg;
            o4_reg   <= o3_reg - o2_reg + o1_reg;
            num4_reg <= o3_reg;
            f1_reg   <= orient_flags(o1_reg, eps_w);
            f2_reg   <= orient_flags(o2_reg, eps_w);
            f3_reg   <= orient_flags(o3_reg, eps_w);
            box4_reg <= box3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: touch and crossing candidate, sign-normalised num/den
    segisect_pkg::orient_flags_t f4, fden;
    logic                        touch5, cand5;
    logic signed [DW-1:0]        den_neg, num_neg;

    always_comb begin
        f4      = orient_flags(o4_reg, eps_w);
        fden    = orient_flags(den4_reg, eps_w);
        touch5  = (f1_reg.nz && box4_reg[0]) || (f2_reg.nz && box4_reg[1]) ||
                  (f3_reg.nz && box4_reg[2]) || (f4.nz && box4_reg[3]);
        cand5   = ((f1_reg.pos && f2_reg.neg) || (f1_reg.neg && f2_reg.pos)) &&
                  ((f3_reg.pos && f4.neg) || (f3_reg.neg && f4.pos)) && !fden.nz;
        den_neg = -den4_reg;
        num_neg = -num4_reg;
    end

    logic [AW-1:0]        dabs5_reg;
    logic signed [DW-1:0] nabs5_reg;
    logic                 touch5_reg, cand5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dabs5_reg  <= den4_reg[DW-1] ? den_neg[AW-1:0] : den4_reg[AW-1:0];
            nabs5_reg  <= den4_reg[DW-1] ? num_neg : num4_reg;
            touch5_reg <= touch5;
            cand5_reg  <= cand5;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: den * eps in two halves
    logic [HL+segisect_pkg::ORIENT_EPS_W-1:0] pl6_reg;
    logic [HH+segisect_pkg::ORIENT_EPS_W-1:0] ph6_reg;
    logic [AW-1:0]                            dabs6_reg;
    logic signed [DW-1:0]                     nabs6_reg;
    logic                                     touch6_reg, cand6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pl6_reg    <= dabs5_reg[HL-1:0] * orient_eps_reg;
            ph6_reg    <= dabs5_reg[AW-1:HL] * orient_eps_reg;
            dabs6_reg  <= dabs5_reg;
            nabs6_reg  <= nabs5_reg;
            touch6_reg <= touch5_reg;
            cand6_reg  <= cand5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: lower window edge lo = den * eps
    logic [LW-1:0]        lo7_reg;
    logic [AW-1:0]        dabs7_reg;
    logic signed [DW-1:0] nabs7_reg;
    logic                 touch7_reg, cand7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lo7_reg    <= {ph6_reg, {HL{1'b0}}} + LW'(pl6_reg);
            dabs7_reg  <= dabs6_reg;
            nabs7_reg  <= nabs6_reg;
            touch7_reg <= touch6_reg;
            cand7_reg  <= cand6_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: upper window edge hi = den * 65536 - lo; num * 65536 > lo
    logic signed [CW-1:0] lhs7;
    assign lhs7 = $signed({nabs7_reg, {segisect_pkg::ORIENT_EPS_W{1'b0}}});

    logic [LW-1:0]        hi8_reg;
    logic signed [CW-1:0] lhs8_reg;
    logic                 gt8_reg, touch8_reg, cand8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hi8_reg    <= {dabs7_reg, {segisect_pkg::ORIENT_EPS_W{1'b0}}} - lo7_reg;
            lhs8_reg   <= lhs7;
            gt8_reg    <= lhs7 > $signed({1'b0, lo7_reg});
            touch8_reg <= touch7_reg;
            cand8_reg  <= cand7_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: result register; touch outranks a crossing
    logic       lt8;
    logic [1:0] kind8;
    logic [1:0] kind_reg;
    logic       hit_reg;

    assign lt8 = lhs8_reg < $signed({1'b0, hi8_reg});

    always_comb begin
        priority if (touch8_reg) begin
            kind8 = segisect_pkg::HIT_TOUCH;
        end else if (cand8_reg && gt8_reg && lt8) begin
            kind8 = segisect_pkg::HIT_CROSS;
        end else begin
            kind8 = segisect_pkg::HIT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind_reg <= kind8;
            hit_reg  <= (kind8 != segisect_pkg::HIT_NONE);
        end
    end

    assign m_tdata = {{(segisect_pkg::OUT_DATA_W - 3){1'b0}}, kind_reg, hit_reg};

    // ------------------------------------------------------------------
    // assertions
    // strict opposite signs of o1, o2 rule out a zero denominator
    `SIT_ASSERT_IMP(a_cand_den_nonzero, aclk, aresetn, v_reg[4] && cand5_reg, dabs5_reg != '0)
    // an accepted beat occupies the first stage next cycle
    `SIT_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, v_reg[0])
    // a stall freezes every valid bit
    `SIT_ASSERT_NXT(a_stall_holds, aclk, aresetn, !en, $stable(v_reg))

endmodule
